@@ src/ppt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

	// field and register widths
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned MARGIN_W = 10;
	localparam int unsigned HOLD_W   = 10;
	localparam int unsigned FACTOR_W = 16;
	localparam int unsigned TIME_W   = 24;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned PERIOD_W = TIME_W + 1;
	localparam int unsigned SQ_W     = 2 * PERIOD_W;
	localparam int unsigned SQ_HALF  = SQ_W / 2;
	localparam int unsigned PP_W     = SQ_HALF + FACTOR_W;
	localparam int unsigned SUM_W    = SQ_W + FACTOR_W;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned LENGTH_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// saturation limit of the millisecond timer
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR  = 2'd2;

	// register values after reset
	localparam logic [MARGIN_W-1:0] MARGIN_RST  = 10'd10;
	localparam logic [HOLD_W-1:0]   HOLDOFF_RST = 10'd500;
	localparam logic [FACTOR_W-1:0] FACTOR_RST  = 16'd16284;

	// measurement phase
	typedef enum logic [3:0] {
		PH_CALIBRATE = 4'b0001,
		PH_WAIT      = 4'b0010,
		PH_MEASURE   = 4'b0100,
		PH_DONE      = 4'b1000
	} phase_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EVAL = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_PP   = 6'b001000,
		ST_SUM  = 6'b010000,
		ST_PUSH = 6'b100000
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic sq;
		logic pp;
		logic sum;
		logic push;
	} cmd_t;

	// status from the datapath, meaningful during evaluation
	typedef struct packed {
		logic hit;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

@@ src/ppt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ppt_ctrl
	import ppt_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   valid_q;

	// sequence one item: latch, evaluate, on a hit (final: length multiply) push
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.hit) begin
					state_d = sts.last ? ST_SQ : ST_PUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_PP;
			end
			ST_PP: begin
				cmd.pp  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				// wait until the output register is free
				if (!valid_q || !out_stall) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = valid_q;

endmodule

`default_nettype wire

@@ src/ppt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ppt_dp
	import ppt_pkg::*;
#(
	parameter int unsigned HIT_COUNT = 10
)
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                   kind,
	input  wire [SAMPLE_W-1:0]    sample,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [INDEX_W-1:0]    hit_index,
	output logic [TIME_W-1:0]     hit_time_ms,
	output logic                  last,
	output logic [PERIOD_W-1:0]   period_ms,
	output logic [LENGTH_W-1:0]   length_um
);

	// configuration registers
	logic [MARGIN_W-1:0] margin_q;
	logic [HOLD_W-1:0]   holdoff_cfg_q;
	logic [FACTOR_W-1:0] factor_q;

	// latched input item
	logic                kind_q;
	logic [SAMPLE_W-1:0] sample_q;

	// measurement state
	phase_t              phase_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [HOLD_W-1:0]   holdoff_q;
	logic [INDEX_W-1:0]  hits_q;
	logic [TIME_W-1:0]   first_q;
	logic [TIME_W-1:0]   prev_q;
	logic [TIME_W-1:0]   avg_q;

	// staged result
	logic [INDEX_W-1:0]  res_idx_q;
	logic [TIME_W-1:0]   res_rel_q;
	logic                res_last_q;

	// length multiply
	logic [SQ_W-1:0]     sq_q;
	logic [PP_W-1:0]     pph_q;
	logic [PP_W-1:0]     ppl_q;
	logic [LENGTH_W-1:0] len_q;

	// output register
	logic [INDEX_W-1:0]  out_idx_q;
	logic [TIME_W-1:0]   out_rel_q;
	logic                out_last_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic [LENGTH_W-1:0] out_len_q;

	logic [SAMPLE_W-1:0] thr_new;
	logic [TIME_W-1:0]   el_next;
	logic [TIME_W-1:0]   gap;
	logic [TIME_W:0]     avg_sum;
	logic [INDEX_W:0]    idx_inc;
	logic                hit;
	logic [PERIOD_W-1:0] period_w;
	logic [SUM_W-1:0]    total;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q      <= MARGIN_RST;
			holdoff_cfg_q <= HOLDOFF_RST;
			factor_q      <= FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MARGIN:  margin_q      <= cfg_wdata[MARGIN_W-1:0];
				CFG_HOLDOFF: holdoff_cfg_q <= cfg_wdata[HOLD_W-1:0];
				CFG_FACTOR:  factor_q      <= cfg_wdata[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			sample_q <= sample;
		end
	end

	// threshold, saturating timer, hit detection
	assign thr_new = (sample_q > margin_q) ? sample_q - margin_q : '0;
	assign el_next = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign gap     = el_next - prev_q;
	assign avg_sum = {1'b0, avg_q} + {1'b0, gap};
	assign idx_inc = {1'b0, hits_q} + 1'b1;
	assign hit     = !kind_q && (phase_q == PH_MEASURE) && (holdoff_q == '0)
		&& (sample_q >= thr_q);

	assign sts.hit  = hit;
	assign sts.last = hit && (idx_inc >= (INDEX_W+1)'(HIT_COUNT));

	// advance the measurement on each evaluated item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CALIBRATE;
			thr_q     <= '0;
			elapsed_q <= '0;
			holdoff_q <= '0;
			hits_q    <= '0;
			first_q   <= '0;
			prev_q    <= '0;
			avg_q     <= '0;
		end else if (cmd.eval) begin
			if (kind_q) begin
				phase_q   <= PH_CALIBRATE;
				thr_q     <= '0;
				elapsed_q <= '0;
				holdoff_q <= '0;
				hits_q    <= '0;
				first_q   <= '0;
				prev_q    <= '0;
				avg_q     <= '0;
			end else begin
				unique case (phase_q)
					PH_CALIBRATE: begin
						thr_q   <= thr_new;
						phase_q <= PH_WAIT;
					end
					PH_WAIT: begin
						if (sample_q < thr_q) begin
							phase_q   <= PH_MEASURE;
							elapsed_q <= '0;
							holdoff_q <= '0;
						end
					end
					PH_MEASURE: begin
						elapsed_q <= el_next;
						if (holdoff_q != '0) begin
							holdoff_q <= holdoff_q - 1'b1;
						end else if (hit) begin
							if (hits_q == '0) begin
								first_q <= el_next;
							end else if (hits_q == INDEX_W'(1)) begin
								avg_q <= gap;
							end else begin
								avg_q <= avg_sum[TIME_W:1];
							end
							prev_q    <= el_next;
							holdoff_q <= holdoff_cfg_q;
							hits_q    <= idx_inc[INDEX_W-1:0];
							if (sts.last) begin
								phase_q <= PH_DONE;
							end
						end
					end
					PH_DONE: ;
					default: ;
				endcase
			end
		end
	end

	// stage the hit report
	always_ff @(posedge clk) begin
		if (cmd.eval && hit) begin
			res_idx_q  <= hits_q;
			res_rel_q  <= (hits_q == '0) ? '0 : el_next - first_q;
			res_last_q <= sts.last;
		end
	end

	// length: square the period, scale by the factor in two halves, sum
	assign period_w = {avg_q, 1'b0};
	assign total    = {pph_q, {SQ_HALF{1'b0}}} + {{SQ_HALF{1'b0}}, ppl_q};

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			sq_q <= {{PERIOD_W{1'b0}}, period_w} * {{PERIOD_W{1'b0}}, period_w};
		end
		if (cmd.pp) begin
			pph_q <= {{FACTOR_W{1'b0}}, sq_q[SQ_W-1:SQ_HALF]}
				* {{SQ_HALF{1'b0}}, factor_q};
			ppl_q <= {{FACTOR_W{1'b0}}, sq_q[SQ_HALF-1:0]}
				* {{SQ_HALF{1'b0}}, factor_q};
		end
		if (cmd.sum) begin
			len_q <= (|total[SUM_W-1:FRAC_W+LENGTH_W]) ? '1
				: total[FRAC_W+LENGTH_W-1:FRAC_W];
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_idx_q    <= res_idx_q;
			out_rel_q    <= res_rel_q;
			out_last_q   <= res_last_q;
			out_period_q <= res_last_q ? period_w : '0;
			out_len_q    <= res_last_q ? len_q : '0;
		end
	end

	assign hit_index   = out_idx_q;
	assign hit_time_ms = out_rel_q;
	assign last        = out_last_q;
	assign period_ms   = out_period_q;
	assign length_um   = out_len_q;

endmodule

`default_nettype wire

@@ src/pendulum_period_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pendulum period timer.
// Input channel (in_valid / in_stall, fields kind and sample): one item per
// millisecond tick carrying a light-sensor sample, or a restart (kind = 1).
// Output channel (out_valid / out_stall): one item per detected hit with its
// index, time relative to the first hit, and on the final hit the period in
// ms and the pendulum length in micrometres.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 threshold
// margin, 1 holdoff ticks, 2 length factor Q0.16); write only while idle.
// Sequence: an item is latched, then evaluated by the sequencer. A tick
// without a hit then returns to idle; a hit moves on to the output push,
// and the final hit first passes the squaring, the two 25x16 partial
// products and the sum, each step in a state of its own. A result is
// loaded into the output register once it is free, then shows on out_valid.
// The output register holds a result while out_stall is high; the next item
// is still accepted and evaluated, and only a following hit waits for it.
// Reset restores the register defaults and returns to calibration.
module pendulum_period_timer
	import ppt_pkg::*;
#(
	parameter int unsigned HIT_COUNT = 10
)
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   kind,
	input  wire [SAMPLE_W-1:0]    sample,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [INDEX_W-1:0]    hit_index,
	output logic [TIME_W-1:0]     hit_time_ms,
	output logic                  last,
	output logic [PERIOD_W-1:0]   period_ms,
	output logic [LENGTH_W-1:0]   length_um
);

	cmd_t cmd;
	sts_t sts;

	ppt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppt_dp #(
		.HIT_COUNT (HIT_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.kind        (kind),
		.sample      (sample),
		.cmd         (cmd),
		.sts         (sts),
		.hit_index   (hit_index),
		.hit_time_ms (hit_time_ms),
		.last        (last),
		.period_ms   (period_ms),
		.length_um   (length_um)
	);

endmodule

`default_nettype wire

@@ src/ppt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ppt_checker
	import ppt_pkg::*;
#(
	parameter int unsigned HIT_COUNT = 10
)
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   out_valid,
	input wire                   out_stall,
	input wire [INDEX_W-1:0]     hit_index,
	input wire [TIME_W-1:0]      hit_time_ms,
	input wire                   last,
	input wire [PERIOD_W-1:0]    period_ms,
	input wire [LENGTH_W-1:0]    length_um
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	// the final hit carries the configured index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> hit_index == INDEX_W'(HIT_COUNT - 1))
		else $error("final hit at wrong index");

	// period and length stay zero before the final hit
	a_zero_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> period_ms == '0 && length_um == '0)
		else $error("period or length reported early");

	// the first hit is the time origin
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_index == '0 |-> hit_time_ms == '0 && !last)
		else $error("first hit not at time zero");

	// the period is twice the half period, hence even
	a_period_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !period_ms[0])
		else $error("odd period");

endmodule

bind pendulum_period_timer ppt_checker #(
	.HIT_COUNT (HIT_COUNT)
) u_ppt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hit_index   (hit_index),
	.hit_time_ms (hit_time_ms),
	.last        (last),
	.period_ms   (period_ms),
	.length_um   (length_um)
);

`default_nettype wire

@@ bench/pendulum_period_timer_tb.sv @@
`timescale 1ns / 1ps

module pendulum_period_timer_tb;
	import ppt_pkg::*;

	localparam int unsigned HITS = 10;
	localparam int unsigned SWEEP_ITEMS = 210;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned SHOWN_FAULTS = 10;

	// one reported hit
	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic [TIME_W-1:0]   rel_ms;
		logic                final_hit;
		logic [PERIOD_W-1:0] period;
		logic [LENGTH_W-1:0] length;
	} hit_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic                  kind;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid;
	logic                  out_stall;
	logic [INDEX_W-1:0]    hit_index;
	logic [TIME_W-1:0]     hit_time_ms;
	logic                  last;
	logic [PERIOD_W-1:0]   period_ms;
	logic [LENGTH_W-1:0]   length_um;

	// shadow copy of the registers
	logic [MARGIN_W-1:0] margin_q;
	logic [HOLD_W-1:0]   holdoff_q;
	logic [FACTOR_W-1:0] factor_q;

	// shadow copy of the measurement state
	phase_t              phase_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [HOLD_W-1:0]   hold_left_q;
	logic [INDEX_W-1:0]  hits_q;
	logic [TIME_W-1:0]   first_q;
	logic [TIME_W-1:0]   prev_q;
	logic [TIME_W-1:0]   half_q;

	hit_t        pending_hits[$];
	int unsigned bad_hits = 0;
	int unsigned send_gap_pct = 13;
	int unsigned recv_stall_pct = 87;

	pendulum_period_timer #(
		.HIT_COUNT(HITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit_index(hit_index),
		.hit_time_ms(hit_time_ms),
		.last(last),
		.period_ms(period_ms),
		.length_um(length_um)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// drop the measurement back to calibration
	function automatic void clear_swing();
		phase_q = PH_CALIBRATE;
		thr_q = '0;
		elapsed_q = '0;
		hold_left_q = '0;
		hits_q = '0;
		first_q = '0;
		prev_q = '0;
		half_q = '0;
	endfunction

	// advance the timer by one transfer and queue the hit it reports
	function automatic void advance_timer(input logic k, input logic [SAMPLE_W-1:0] s);
		logic [TIME_W-1:0] gap;
		logic [TIME_W:0]   sum;
		logic [SQ_W-1:0]   sq;
		logic [63:0]       len;
		hit_t              h;
		if (k) begin
			clear_swing();
			return;
		end
		case (phase_q)
			PH_CALIBRATE: begin
				thr_q = (s > margin_q) ? s - margin_q : '0;
				phase_q = PH_WAIT;
			end
			PH_WAIT: begin
				if (s < thr_q) begin
					phase_q = PH_MEASURE;
					elapsed_q = '0;
					hold_left_q = '0;
				end
			end
			PH_MEASURE: begin
				if (elapsed_q != TIME_MAX)
					elapsed_q = elapsed_q + 1'b1;
				if (hold_left_q != 0) begin
					hold_left_q = hold_left_q - 1'b1;
				end else if (s >= thr_q) begin
					if (hits_q == 0) begin
						first_q = elapsed_q;
					end else begin
						gap = elapsed_q - prev_q;
						if (hits_q == 1) begin
							half_q = gap;
						end else begin
							sum = half_q + gap;
							half_q = sum[TIME_W:1];
						end
					end
					prev_q = elapsed_q;
					hold_left_q = holdoff_q;
					h.index = hits_q;
					h.rel_ms = elapsed_q - first_q;
					h.final_hit = (int'(hits_q) + 1 >= HITS);
					h.period = '0;
					h.length = '0;
					hits_q = hits_q + 1'b1;
					if (h.final_hit) begin
						h.period = {half_q, 1'b0};
						sq = h.period * h.period;
						len = 64'(sq >> FRAC_W) * factor_q
							+ ((64'(sq[FRAC_W-1:0]) * factor_q) >> FRAC_W);
						h.length = (len > 64'hFFFF_FFFF) ? '1 : len[LENGTH_W-1:0];
						phase_q = PH_DONE;
					end
					pending_hits.push_back(h);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] any_sample();
		return SAMPLE_W'($urandom);
	endfunction

	// below the threshold; only called once the threshold is nonzero
	function automatic logic [SAMPLE_W-1:0] low_sample();
		return SAMPLE_W'($urandom_range(thr_q - 1, 0));
	endfunction

	function automatic logic [SAMPLE_W-1:0] high_sample();
		return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1, thr_q));
	endfunction

	// offer one transfer, hold it until accepted, then predict
	task automatic send_item(input logic k, input logic [SAMPLE_W-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sample <= s;
		do
			@(posedge clk);
		while (in_stall);
		advance_timer(k, s);
	endtask

	task automatic tick(input logic [SAMPLE_W-1:0] s);
		send_item(1'b0, s);
	endtask

	task automatic restart();
		send_item(1'b1, any_sample());
	endtask

	// go idle and wait until every hit is out and the pipeline is empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MARGIN: margin_q = data[MARGIN_W-1:0];
			CFG_HOLDOFF: holdoff_q = data[HOLD_W-1:0];
			CFG_FACTOR: factor_q = data[FACTOR_W-1:0];
			default: begin
			end
		endcase
	endtask

	// write all three registers; unused upper bits carry noise
	task automatic configure(input logic [MARGIN_W-1:0] m, input logic [HOLD_W-1:0] h,
			input logic [FACTOR_W-1:0] f);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[MARGIN_W-1:0] = m;
		write_reg(CFG_MARGIN, data);
		data = CFG_DATA_W'($urandom);
		data[HOLD_W-1:0] = h;
		write_reg(CFG_HOLDOFF, data);
		write_reg(CFG_FACTOR, f);
	endtask

	// restart, calibrate on cal and drop below the threshold
	task automatic arm(input logic [SAMPLE_W-1:0] cal);
		restart();
		tick(cal);
		tick(low_sample());
	endtask

	// next hit g ticks after the previous one, or later if holdoff demands it
	task automatic swing_gap(input int unsigned g);
		repeat (g - 1)
			tick(hold_left_q != 0 ? any_sample() : low_sample());
		while (hold_left_q != 0)
			tick(any_sample());
		tick(high_sample());
	endtask

	task automatic test_defaults();
		arm(10'd600);
		tick(thr_q);
		tick(10'h3FF);
		tick(10'h3FF);
		restart();
		tick(10'd5);
		tick(10'd0);
		tick(10'h3FF);
		settle();
	endtask

	task automatic test_threshold_edges();
		// full margin floors the threshold at zero, so no drop ever comes
		configure(10'h3FF, 10'd0, 16'hFFFF);
		restart();
		tick(10'h3FF);
		tick(10'd0);
		tick(10'h3FF);
		settle();
		// zero margin: the calibration sample itself is the threshold
		configure(10'd0, 10'd0, 16'hFFFF);
		restart();
		tick(10'h3FF);
		tick(10'h3FF);
		tick(10'h3FE);
		tick(10'h3FF);
		tick(10'h3FE);
		tick(10'h3FF);
		restart();
		tick(10'd0);
		tick(10'd0);
		settle();
	endtask

	task automatic test_full_run();
		configure(10'd7, 10'd0, 16'hFFFF);
		arm(10'd512);
		swing_gap(1);
		for (int unsigned i = 1; i < HITS; i++)
			swing_gap(i);
		// finished: further ticks are ignored until a restart
		tick(10'h3FF);
		tick(thr_q);
		send_item(1'b1, 10'h3FF);
		tick(10'd0);
		settle();
	endtask

	task automatic test_holdoff_extremes();
		// longest holdoff: strong samples right after a hit are ignored
		configure(10'd20, 10'h3FF, 16'd40000);
		arm(10'd900);
		swing_gap(1);
		repeat (5)
			tick(10'h3FF);
		restart();
		settle();
		configure(10'd1, 10'd1, 16'd0);
		arm(10'd300);
		for (int unsigned i = 0; i < HITS; i++)
			swing_gap($urandom_range(40, 1));
		settle();
	endtask

	// mostly well-formed swings with random content, some broken ones
	task automatic sweep_swings(input int unsigned n);
		int unsigned counted;
		int unsigned roll;
		counted = 0;
		while (counted < n) begin
			roll = $urandom_range(99);
			counted++;
			if (roll < 2) begin
				restart();
			end else begin
				case (phase_q)
					PH_CALIBRATE: begin
						tick(roll < 10 ? SAMPLE_W'($urandom_range(margin_q, 0)) : any_sample());
					end
					PH_WAIT: begin
						tick((thr_q != 0 && roll < 75) ? low_sample() : any_sample());
					end
					PH_MEASURE: begin
						if (hold_left_q != 0)
							tick(any_sample());
						else
							tick(roll < 40 ? high_sample() : low_sample());
					end
					default: begin
						if (roll < 40) begin
							restart();
						end else begin
							counted--;
							tick(any_sample());
						end
					end
				endcase
			end
		end
	endtask

	task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
			input logic [MARGIN_W-1:0] m, input logic [HOLD_W-1:0] h,
			input logic [FACTOR_W-1:0] f);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		settle();
		configure(m, h, f);
		sweep_swings(SWEEP_ITEMS);
		settle();
		configure(MARGIN_W'($urandom_range(300, 1)), HOLD_W'($urandom_range(20, 0)),
			FACTOR_W'($urandom));
		sweep_swings(SWEEP_ITEMS);
		settle();
	endtask

	// one long final gap with the largest factor
	task automatic test_long_final_gap();
		configure(10'd0, 10'd0, 16'hFFFF);
		arm(10'h3FF);
		repeat (HITS - 1)
			swing_gap(1);
		swing_gap(60);
		settle();
	endtask

	// vary the receiver stall each cycle
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// compare each output transfer with the oldest predicted hit
	always @(posedge clk) begin
		hit_t seen;
		hit_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {hit_index, hit_time_ms, last, period_ms, length_um};
			if (pending_hits.size() == 0) begin
				bad_hits++;
				if (bad_hits <= SHOWN_FAULTS)
					$display("unexpected hit: idx %0d t %0d last %0b period %0d len %0d",
						seen.index, seen.rel_ms, seen.final_hit, seen.period, seen.length);
			end else begin
				want = pending_hits.pop_front();
				if (seen.index !== want.index || seen.rel_ms !== want.rel_ms
						|| seen.final_hit !== want.final_hit || seen.period !== want.period
						|| seen.length !== want.length) begin
					bad_hits++;
					if (bad_hits <= SHOWN_FAULTS) begin
						$display("hit mismatch: want idx %0d t %0d last %0b period %0d len %0d",
							want.index, want.rel_ms, want.final_hit, want.period, want.length);
						$display("              got  idx %0d t %0d last %0b period %0d len %0d",
							seen.index, seen.rel_ms, seen.final_hit, seen.period, seen.length);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		margin_q = MARGIN_RST;
		holdoff_q = HOLDOFF_RST;
		factor_q = FACTOR_RST;
		clear_swing();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_threshold_edges();
		test_full_run();
		test_holdoff_extremes();
		test_random_traffic(13, 87, 10'd0, 10'd0, 16'hFFFF);
		test_random_traffic(87, 13, 10'd150, 10'd3, FACTOR_RST);
		test_random_traffic(0, 0, 10'd25, 10'd10, 16'd1);
		test_long_final_gap();

		settle();
		if (bad_hits == 0 && pending_hits.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
